// ===== src/clock_time_to_led_rows_core_assert.svh =====
// ----------------------------------------------------------------------------
// clock_time_to_led_rows_core_assert.svh
// assertion macros shared by the clock face renderer modules
// ----------------------------------------------------------------------------
`ifndef CLOCK_TIME_TO_LED_ROWS_CORE_ASSERT_SVH
`define CLOCK_TIME_TO_LED_ROWS_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked only outside reset
`define CLTTL_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("clttl assertion failed");
// checked at every edge, reset included
`define CLTTL_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("clttl assertion failed");
`else
`define CLTTL_ASSERT(name, prop)
`define CLTTL_ASSERT_ALWAYS(name, prop)
`endif
`endif

// ===== src/clttl_pkg.sv =====
// ----------------------------------------------------------------------------
// clttl_pkg
// types, glyph tables and residue tables of the clock face renderer
// ----------------------------------------------------------------------------
package clttl_pkg;

  localparam int unsigned EpochW   = 40;
  localparam int unsigned OffsetW  = 17;
  localparam int unsigned RowW     = 32;
  localparam int unsigned NumRows  = 8;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned DataW    = 32;

  localparam logic [OffsetW-1:0] ZoneOffsetReset = 17'd19800;

  // 86400 = 128 * 675, so seconds of day come from the high part mod 675
  localparam int unsigned DayDiv    = 675;
  localparam int unsigned ResChunks = 5;

  typedef logic [ResChunks-1:0][255:0][9:0] res_tbl_t;

  // entry [k][v] = (v * 2^(8k)) mod 675
  function automatic res_tbl_t build_res_tbl();
    res_tbl_t    tbl;
    int unsigned pw;
    pw = 1;
    for (int k = 0; k < ResChunks; k++) begin
      for (int v = 0; v < 256; v++) begin
        tbl[k][v] = 10'((v * pw) % DayDiv);
      end
      pw = (pw * 256) % DayDiv;
    end
    return tbl;
  endfunction

  localparam res_tbl_t ResTbl = build_res_tbl();

  typedef enum logic [1:0] {
    RegZoneOffset = 2'd0,
    RegHourMode   = 2'd1,
    RegRenderEn   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    IconMonitor = 2'd0,
    IconSun     = 2'd1,
    IconHouse   = 2'd2
  } icon_e;

  typedef struct packed {
    logic [OffsetW-1:0] zone_offset;
    logic               hour24;
    logic               render_en;
  } cfg_t;

  typedef struct packed {
    logic render;
    logic colon;
  } tag_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

  localparam logic [4:0] DigitGlyph [10][8] = '{
    '{5'd12, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd12},
    '{5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4 },
    '{5'd28, 5'd2,  5'd2,  5'd12, 5'd16, 5'd16, 5'd16, 5'd14},
    '{5'd28, 5'd2,  5'd2,  5'd28, 5'd2,  5'd2,  5'd2,  5'd28},
    '{5'd16, 5'd16, 5'd16, 5'd20, 5'd20, 5'd30, 5'd4,  5'd4 },
    '{5'd30, 5'd16, 5'd16, 5'd28, 5'd2,  5'd2,  5'd2,  5'd28},
    '{5'd14, 5'd16, 5'd16, 5'd28, 5'd18, 5'd18, 5'd18, 5'd12},
    '{5'd30, 5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd2 },
    '{5'd12, 5'd18, 5'd18, 5'd12, 5'd18, 5'd18, 5'd18, 5'd12},
    '{5'd12, 5'd18, 5'd18, 5'd14, 5'd2,  5'd2,  5'd2,  5'd12}
  };

  localparam logic [3:0] ColonGlyph [8] = '{
    4'd0, 4'd14, 4'd14, 4'd0, 4'd0, 4'd14, 4'd14, 4'd0
  };

  localparam logic [7:0] IconGlyph [3][8] = '{
    '{8'd0,  8'd254, 8'd254, 8'd254, 8'd254, 8'd16,  8'd124, 8'd0  },
    '{8'd7,  8'd3,   8'd5,   8'd32,  8'd113, 8'd251, 8'd255, 8'd255},
    '{8'd24, 8'd60,  8'd126, 8'd255, 8'd66,  8'd70,  8'd66,  8'd126}
  };

endpackage

// ===== src/clttl_regs.sv =====
// ----------------------------------------------------------------------------
// clttl_regs
// apb configuration registers: zone offset, hour mode, render enable
// ----------------------------------------------------------------------------
module clttl_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [clttl_pkg::AddrW-1:0] paddr,
  input  logic [clttl_pkg::DataW-1:0] pwdata,
  output logic [clttl_pkg::DataW-1:0] prdata,
  output logic                        pready,
  output clttl_pkg::cfg_t             cfg_o
);

  clttl_pkg::cfg_t      cfg_q;
  clttl_pkg::reg_idx_e  reg_idx;
  logic                 wr_en;

  assign reg_idx = clttl_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zone_offset <= clttl_pkg::ZoneOffsetReset;
      cfg_q.hour24      <= 1'b0;
      cfg_q.render_en   <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        clttl_pkg::RegZoneOffset: cfg_q.zone_offset <= pwdata[clttl_pkg::OffsetW-1:0];
        clttl_pkg::RegHourMode:   cfg_q.hour24      <= pwdata[0];
        clttl_pkg::RegRenderEn:   cfg_q.render_en   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      clttl_pkg::RegZoneOffset: prdata = {15'd0, cfg_q.zone_offset};
      clttl_pkg::RegHourMode:   prdata = {31'd0, cfg_q.hour24};
      clttl_pkg::RegRenderEn:   prdata = {31'd0, cfg_q.render_en};
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/clttl_split.sv =====
// ----------------------------------------------------------------------------
// clttl_split
// pipeline from epoch seconds plus zone offset to hour, minute and second
// ----------------------------------------------------------------------------
`include "clock_time_to_led_rows_core_assert.svh"

module clttl_split (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [clttl_pkg::OffsetW-1:0] zone_offset_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [clttl_pkg::EpochW-1:0]  epoch_i,
  input  clttl_pkg::tag_t               in_tag_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output clttl_pkg::hms_t               out_hms_o,
  output clttl_pkg::tag_t               out_tag_o
);

  localparam int unsigned Stages  = 6;
  localparam int unsigned Recip60 = 34952;  // floor(2^21 / 60)

  typedef struct packed {
    logic [11:0] quo;
    logic [5:0]  rem;
  } div60_t;

  // reciprocal estimate is low by at most one, one compare fixes it
  function automatic div60_t div60(input logic [16:0] val);
    logic [32:0] prod;
    logic [11:0] qe;
    logic [17:0] mul;
    logic [17:0] diff;
    logic [6:0]  re;
    div60_t      res;
    prod = 33'(val) * 33'(Recip60);
    qe   = prod[32:21];
    mul  = {qe, 6'b0} - {4'b0, qe, 2'b0};
    diff = {1'b0, val} - mul;
    re   = diff[6:0];
    if (re >= 7'd60) begin
      res.quo = qe + 12'd1;
      res.rem = 6'(re - 7'd60);
    end else begin
      res.quo = qe;
      res.rem = re[5:0];
    end
    return res;
  endfunction

  logic [Stages-1:0]  valid_q;
  logic [Stages-1:0]  valid_in;
  logic [Stages-1:0]  ready;
  clttl_pkg::tag_t    tag_q [Stages];

  logic [clttl_pkg::EpochW-1:0] epoch_q;
  logic [41:0]                  sum;
  logic [40:0]                  t_d, t_q;
  logic [33:0]                  hi;
  logic [11:0]                  r_d, r_q;
  logic [6:0]                   lo_q;
  logic [11:0]                  x_full;
  logic [16:0]                  s_d, s_q;
  div60_t                       sec_div, min_div;
  logic [10:0]                  tm_q;
  logic [5:0]                   sec_q;
  clttl_pkg::hms_t              hms_d, hms_q;

  // each stage loads when empty or when the one after it moves on
  always_comb begin
    ready[Stages-1] = !valid_q[Stages-1] || out_ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  assign valid_in   = {valid_q[Stages-2:0], in_valid_i};
  assign in_ready_o = ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < Stages; k++) begin
        if (ready[k]) begin
          valid_q[k] <= valid_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      tag_q[0] <= in_tag_i;
    end
    for (int k = 1; k < Stages; k++) begin
      if (ready[k]) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  // offset add, a negative sum clamps to zero
  assign sum = {2'b00, epoch_q}
             + {{(42 - clttl_pkg::OffsetW){zone_offset_i[clttl_pkg::OffsetW-1]}},
                zone_offset_i};
  assign t_d = sum[41] ? '0 : sum[40:0];

  // high part mod 675, one table per byte
  assign hi  = t_q[40:7];
  assign r_d = 12'(clttl_pkg::ResTbl[0][hi[7:0]])
             + 12'(clttl_pkg::ResTbl[1][hi[15:8]])
             + 12'(clttl_pkg::ResTbl[2][hi[23:16]])
             + 12'(clttl_pkg::ResTbl[3][hi[31:24]])
             + 12'(clttl_pkg::ResTbl[4][{6'b0, hi[33:32]}]);

  // partial sum stays below 5 * 675
  always_comb begin
    priority if (r_q >= 12'(4 * clttl_pkg::DayDiv)) begin
      x_full = r_q - 12'(4 * clttl_pkg::DayDiv);
    end else if (r_q >= 12'(3 * clttl_pkg::DayDiv)) begin
      x_full = r_q - 12'(3 * clttl_pkg::DayDiv);
    end else if (r_q >= 12'(2 * clttl_pkg::DayDiv)) begin
      x_full = r_q - 12'(2 * clttl_pkg::DayDiv);
    end else if (r_q >= 12'(clttl_pkg::DayDiv)) begin
      x_full = r_q - 12'(clttl_pkg::DayDiv);
    end else begin
      x_full = r_q;
    end
  end

  assign s_d = {x_full[9:0], lo_q};

  assign sec_div = div60(s_q);
  assign min_div = div60({6'b0, tm_q});

  always_comb begin
    hms_d.hour   = min_div.quo[4:0];
    hms_d.minute = min_div.rem;
    hms_d.second = sec_q;
  end

  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      epoch_q <= epoch_i;
    end
    if (ready[1]) begin
      t_q <= t_d;
    end
    if (ready[2]) begin
      r_q  <= r_d;
      lo_q <= t_q[6:0];
    end
    if (ready[3]) begin
      s_q <= s_d;
    end
    if (ready[4]) begin
      tm_q  <= sec_div.quo[10:0];
      sec_q <= sec_div.rem;
    end
    if (ready[5]) begin
      hms_q <= hms_d;
    end
  end

  assign out_valid_o = valid_q[Stages-1];
  assign out_hms_o   = hms_q;
  assign out_tag_o   = tag_q[Stages-1];

  `CLTTL_ASSERT(hour_range_a, out_valid_o |-> out_hms_o.hour <= 5'd23)
  `CLTTL_ASSERT(minute_range_a, out_valid_o |-> out_hms_o.minute <= 6'd59)
  `CLTTL_ASSERT(second_range_a, out_valid_o |-> out_hms_o.second <= 6'd59)

endmodule

// ===== src/clttl_render.sv =====
// ----------------------------------------------------------------------------
// clttl_render
// glyph row assembly and result register of the clock face
// ----------------------------------------------------------------------------
`include "clock_time_to_led_rows_core_assert.svh"

module clttl_render (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        hour24_i,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  clttl_pkg::hms_t                             in_hms_i,
  input  clttl_pkg::tag_t                             in_tag_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic [clttl_pkg::NumRows-1:0][clttl_pkg::RowW-1:0] rows_o,
  output clttl_pkg::hms_t                             out_hms_o
);

  // tens digit in the upper bits, units in the lower four
  function automatic logic [6:0] tens_units(input logic [5:0] val);
    logic [2:0] tn;
    logic [5:0] un;
    priority if (val >= 6'd50) begin
      tn = 3'd5;
      un = val - 6'd50;
    end else if (val >= 6'd40) begin
      tn = 3'd4;
      un = val - 6'd40;
    end else if (val >= 6'd30) begin
      tn = 3'd3;
      un = val - 6'd30;
    end else if (val >= 6'd20) begin
      tn = 3'd2;
      un = val - 6'd20;
    end else if (val >= 6'd10) begin
      tn = 3'd1;
      un = val - 6'd10;
    end else begin
      tn = 3'd0;
      un = val;
    end
    return {tn, un[3:0]};
  endfunction

  logic                 load;
  logic                 out_valid_q;
  logic [4:0]           shown;
  clttl_pkg::icon_e     icon;
  logic [6:0]           hour_tu;
  logic [6:0]           min_tu;
  logic [3:0]           ht, hu, mt, mu;
  logic [clttl_pkg::NumRows-1:0][clttl_pkg::RowW-1:0] rows_d, rows_q;
  clttl_pkg::hms_t      hms_q;
  logic                 colon_ok;

  assign load       = !out_valid_q || out_ready_i;
  assign in_ready_o = load;

  always_comb begin
    priority if (hour24_i) begin
      shown = in_hms_i.hour;
      icon  = clttl_pkg::IconHouse;
    end else if (in_hms_i.hour <= 5'd12) begin
      shown = in_hms_i.hour;
      icon  = clttl_pkg::IconSun;
    end else begin
      shown = in_hms_i.hour - 5'd12;
      icon  = clttl_pkg::IconMonitor;
    end
  end

  assign hour_tu = tens_units({1'b0, shown});
  assign min_tu  = tens_units(in_hms_i.minute);
  assign ht      = {1'b0, hour_tu[6:4]};
  assign hu      = hour_tu[3:0];
  assign mt      = {1'b0, min_tu[6:4]};
  assign mu      = min_tu[3:0];

  // left to right: hour tens, hour units, colon, minute tens, minute units, icon
  always_comb begin
    for (int r = 0; r < clttl_pkg::NumRows; r++) begin
      rows_d[r] = {clttl_pkg::DigitGlyph[ht][r],
                   clttl_pkg::DigitGlyph[hu][r],
                   in_tag_i.colon ? clttl_pkg::ColonGlyph[r] : 4'd0,
                   clttl_pkg::DigitGlyph[mt][r],
                   clttl_pkg::DigitGlyph[mu][r],
                   clttl_pkg::IconGlyph[icon][r]};
    end
  end

  // ticks with rendering off are dropped here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= in_valid_i && in_tag_i.render;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rows_q <= rows_d;
      hms_q  <= in_hms_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rows_o      = rows_q;
  assign out_hms_o   = hms_q;

  // colon columns: blank in the top row, rows 1 and 5 agree and are blank or lit
  assign colon_ok = (rows_o[0][21:18] == 4'd0)
                 && (rows_o[1][21:18] == rows_o[5][21:18])
                 && (rows_o[1][21:18] == 4'd0 || rows_o[1][21:18] == 4'd14);

  `CLTTL_ASSERT_ALWAYS(no_out_in_reset_a, !rst_ni |-> !out_valid_o)
  `CLTTL_ASSERT(colon_rows_agree_a, out_valid_o |-> colon_ok)
  `CLTTL_ASSERT(hold_while_stalled_a, out_valid_o && !out_ready_i |=> out_valid_o && $stable(rows_o))

endmodule

// ===== src/clock_time_to_led_rows_core.sv =====
// ----------------------------------------------------------------------------
// clock_time_to_led_rows_core
// clock face renderer: epoch seconds in, eight 32-bit led matrix rows out
//
// input channel: one transfer per tick carries epoch_seconds_i. output
// channel: one transfer per rendered tick carries row_0_o..row_7_o and the
// hour, minute and second after the zone offset. with render enable low a
// tick gives no output transfer and leaves the colon phase alone.
// out_valid_o follows the input transfer through seven register stages
// (input, offset add, residue table sum, day seconds, divide by 60 twice,
// result register). throughput: one item per cycle while the receiver
// takes results, since every stage loads while the one after it moves on.
// a stalled receiver holds the result register; earlier stages keep filling
// until the pipeline is full, then in_ready_o drops.
// reset clears all valid bits, sets the colon phase so the first frame shows
// the colon, and loads zone offset 19800, 12-hour mode and render enable.
// config goes through the apb port at byte addresses 0, 4 and 8; it is to be
// written only while no tick is in flight, which the block does not enforce.
// ----------------------------------------------------------------------------
module clock_time_to_led_rows_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [clttl_pkg::AddrW-1:0]   paddr,
  input  logic [clttl_pkg::DataW-1:0]   pwdata,
  output logic [clttl_pkg::DataW-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [clttl_pkg::EpochW-1:0]  epoch_seconds_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [clttl_pkg::RowW-1:0]    row_0_o,
  output logic [clttl_pkg::RowW-1:0]    row_1_o,
  output logic [clttl_pkg::RowW-1:0]    row_2_o,
  output logic [clttl_pkg::RowW-1:0]    row_3_o,
  output logic [clttl_pkg::RowW-1:0]    row_4_o,
  output logic [clttl_pkg::RowW-1:0]    row_5_o,
  output logic [clttl_pkg::RowW-1:0]    row_6_o,
  output logic [clttl_pkg::RowW-1:0]    row_7_o,
  output logic [4:0]                    hour_of_day_o,
  output logic [5:0]                    minute_of_hour_o,
  output logic [5:0]                    second_of_minute_o
);

  clttl_pkg::cfg_t   cfg;
  clttl_pkg::tag_t   in_tag;
  clttl_pkg::tag_t   split_tag;
  clttl_pkg::hms_t   split_hms;
  clttl_pkg::hms_t   out_hms;
  logic              split_valid;
  logic              split_ready;
  logic              colon_q;
  logic [clttl_pkg::NumRows-1:0][clttl_pkg::RowW-1:0] rows;

  clttl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // colon phase flips once per rendered tick, tagged at the input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colon_q <= 1'b1;
    end else if (in_valid_i && in_ready_o && cfg.render_en) begin
      colon_q <= !colon_q;
    end
  end

  assign in_tag.render = cfg.render_en;
  assign in_tag.colon  = colon_q;

  clttl_split u_split (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .zone_offset_i (cfg.zone_offset),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .epoch_i       (epoch_seconds_i),
    .in_tag_i      (in_tag),
    .out_valid_o   (split_valid),
    .out_ready_i   (split_ready),
    .out_hms_o     (split_hms),
    .out_tag_o     (split_tag)
  );

  clttl_render u_render (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hour24_i    (cfg.hour24),
    .in_valid_i  (split_valid),
    .in_ready_o  (split_ready),
    .in_hms_i    (split_hms),
    .in_tag_i    (split_tag),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rows_o      (rows),
    .out_hms_o   (out_hms)
  );

  assign row_0_o            = rows[0];
  assign row_1_o            = rows[1];
  assign row_2_o            = rows[2];
  assign row_3_o            = rows[3];
  assign row_4_o            = rows[4];
  assign row_5_o            = rows[5];
  assign row_6_o            = rows[6];
  assign row_7_o            = rows[7];
  assign hour_of_day_o      = out_hms.hour;
  assign minute_of_hour_o   = out_hms.minute;
  assign second_of_minute_o = out_hms.second;

endmodule
